@@ rtl/core/irps_pkg.sv @@
// Package for the IR proximity sequencer: widths, payload word types, codes
// and the control group passed to the classifier. No dependencies.
`timescale 1ns / 1ps

package irps_pkg;

	localparam int WINDOW_DEPTH = 8;
	localparam int WARMUP_TICKS = 4;

	localparam int SAMPLE_W = 10;
	localparam int THRESH_W = 13;
	localparam int LEVEL_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
	localparam int TOTAL_W   = SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int CMP_W     = (TOTAL_W > THRESH_W) ? TOTAL_W : THRESH_W;
	localparam int WARM_W    = (WARMUP_TICKS > 0) ? $clog2(WARMUP_TICKS + 1) : 1;
	localparam int ADDR_W    = SLOT_W + 2;
	localparam int MEM_DEPTH = 3 << SLOT_W;

	// Window selector; it also forms the upper bits of the memory address.
	typedef enum logic [1:0] {
		KIND_FAR  = 2'd0,
		KIND_OFF  = 2'd1,
		KIND_NEAR = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	localparam logic [LEVEL_W-1:0] LEVEL_OFF         = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_APPROACHING = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_ON          = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_SATURATED   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FAR_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIMPLE_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_THRESHOLD    = 2'd2;

	localparam logic [THRESH_W-1:0] FAR_THRESHOLD_RST    = 13'd80;
	localparam logic [THRESH_W-1:0] SIMPLE_THRESHOLD_RST = 13'd240;
	localparam logic [THRESH_W-1:0] SAT_THRESHOLD_RST    = 13'd6960;

	typedef struct packed {
		logic [SAMPLE_W-1:0] adc_sample;
		logic                differential_mode;
	} in_t;

	typedef struct packed {
		logic               far_led_on;
		logic               near_led_on;
		logic               thermistor_selected;
		logic [LEVEL_W-1:0] proximity_level;
	} out_t;

	typedef struct packed {
		logic differential;
		logic running;
	} cls_ctrl_t;

endpackage

@@ rtl/core/irps_classify.sv @@
// Two-stage proximity classifier: ambient correction and saturation check,
// then the threshold and near/far ratio tests. Depends on irps_pkg.
`timescale 1ns / 1ps

module irps_classify (
	input  logic                             clk,
	input  logic                             adv,
	input  irps_pkg::cls_ctrl_t              ctrl,
	input  logic [irps_pkg::TOTAL_W-1:0]     far_total,
	input  logic [irps_pkg::TOTAL_W-1:0]     off_total,
	input  logic [irps_pkg::TOTAL_W-1:0]     near_total,
	input  logic [irps_pkg::THRESH_W-1:0]    far_threshold,
	input  logic [irps_pkg::THRESH_W-1:0]    simple_near_threshold,
	input  logic [irps_pkg::THRESH_W-1:0]    saturation_threshold,
	output logic [irps_pkg::LEVEL_W-1:0]     level
);

	logic [irps_pkg::CMP_W-1:0] far_x, near_x, sat_x;
	logic                       sat_d;
	logic [irps_pkg::TOTAL_W-1:0] near_c, far_c;

	irps_pkg::cls_ctrl_t          ctrl_s3;
	logic                         sat_s3;
	logic [irps_pkg::TOTAL_W-1:0] near_s3, far_s3;

	logic [irps_pkg::CMP_W-1:0]   near_e, far_e, far_th_x, simple_th_x;
	logic [irps_pkg::TOTAL_W+2:0] near6, far5;
	logic                         far_ok;

	always_comb begin
		far_x  = irps_pkg::CMP_W'(far_total);
		near_x = irps_pkg::CMP_W'(near_total);
		sat_x  = irps_pkg::CMP_W'(saturation_threshold);
		sat_d  = (near_x >= sat_x) || (far_x >= sat_x);
		near_c = (near_total > off_total) ? near_total - off_total : '0;
		far_c  = (far_total > off_total) ? far_total - off_total : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s3 <= ctrl;
			sat_s3  <= sat_d;
			near_s3 <= near_c;
			far_s3  <= far_c;
		end
	end

	always_comb begin
		near_e      = irps_pkg::CMP_W'(near_s3);
		far_e       = irps_pkg::CMP_W'(far_s3);
		far_th_x    = irps_pkg::CMP_W'(far_threshold);
		simple_th_x = irps_pkg::CMP_W'(simple_near_threshold);
		// Ratio test 6*near >= 5*far done with shifts and adds.
		near6  = ((irps_pkg::TOTAL_W+3)'(near_s3) << 2) + ((irps_pkg::TOTAL_W+3)'(near_s3) << 1);
		far5   = ((irps_pkg::TOTAL_W+3)'(far_s3) << 2) + (irps_pkg::TOTAL_W+3)'(far_s3);
		far_ok = far_e >= far_th_x;
		if (!ctrl_s3.running) begin
			level = irps_pkg::LEVEL_OFF;
		end else if (sat_s3) begin
			level = irps_pkg::LEVEL_SATURATED;
		end else if (!ctrl_s3.differential) begin
			level = (near_e >= simple_th_x) ? irps_pkg::LEVEL_ON : irps_pkg::LEVEL_OFF;
		end else if (far_ok && (near_s3 > far_s3)) begin
			level = irps_pkg::LEVEL_ON;
		end else if (far_ok && (near6 >= far5)) begin
			level = irps_pkg::LEVEL_APPROACHING;
		end else begin
			level = irps_pkg::LEVEL_OFF;
		end
	end

endmodule

@@ rtl/core/ir_proximity_sequencer.sv @@
// Top level of the IR proximity sequencer: phase sequencing, sample window
// memory with running sums, and the output register. Uses irps_pkg, irps_classify.
`timescale 1ns / 1ps

// Channel   Direction  Word                 Handshake
// in        input      irps_pkg::in_t       in_valid / in_ready
// out       output     irps_pkg::out_t      out_valid / out_ready
// cfg       input      index + 13-bit data  cfg_valid / cfg_ready (always ready)
//
// One tick is accepted per cycle while no result waits at the output; out_valid rises once
// the tick has moved through the stage registers and into the output register.
// The window samples sit in one synchronous memory, read on acceptance and written
// back from stage 1, so the running sums keep pace at one tick a cycle while the pipeline is not held.
// Reset clears the phase, warm-up count, LED and select state, the sums and
// the per-entry valid bits, so the windows read as zero without a clearing pass.
// The whole pipeline holds while a result waits at the output.

module ir_proximity_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  irps_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output irps_pkg::out_t                    out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [irps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [irps_pkg::THRESH_W-1:0]     cfg_data
);

	logic adv, accept, running;

	logic [irps_pkg::THRESH_W-1:0] far_th_q, simple_th_q, sat_th_q;

	logic [3:0]                  phase_q;
	logic [irps_pkg::WARM_W-1:0] warm_q;
	logic                        far_led_q, near_led_q, therm_q;
	logic                        far_led_d, near_led_d, therm_d;
	logic [irps_pkg::SLOT_W-1:0] far_slot_q, off_slot_q, near_slot_q;
	logic [irps_pkg::SLOT_W-1:0] slot_sel, slot_next;
	irps_pkg::kind_t             file_kind;
	logic                        file_en;
	logic [irps_pkg::ADDR_W-1:0] rd_addr;

	logic [irps_pkg::SAMPLE_W-1:0] mem [irps_pkg::MEM_DEPTH];
	logic [irps_pkg::MEM_DEPTH-1:0] entry_vld_q;

	// Stage 1: old window entry is back from memory.
	logic                          valid_s1, file_s1, rd_vld_s1;
	irps_pkg::kind_t               kind_s1;
	logic [irps_pkg::ADDR_W-1:0]   addr_s1;
	logic [irps_pkg::SAMPLE_W-1:0] sample_s1, rd_s1, old_s1;
	irps_pkg::cls_ctrl_t           ctrl_s1;
	logic [2:0]                    leds_s1;
	logic [irps_pkg::TOTAL_W-1:0]  total_sel, total_new;

	logic [irps_pkg::TOTAL_W-1:0] far_total_q, off_total_q, near_total_q;

	// Stage 2 reads the updated sums; stage 3 sits inside the classifier.
	logic                 valid_s2, valid_s3;
	irps_pkg::cls_ctrl_t  ctrl_s2;
	logic [2:0]           leds_s2, leds_s3;
	logic [irps_pkg::LEVEL_W-1:0] level;

	logic           out_valid_q;
	irps_pkg::out_t out_data_q;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign accept    = in_valid && adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign running   = warm_q >= irps_pkg::WARM_W'(irps_pkg::WARMUP_TICKS);

	always_comb begin
		file_kind  = irps_pkg::KIND_NONE;
		far_led_d  = far_led_q;
		near_led_d = near_led_q;
		therm_d    = therm_q;
		case (phase_q)
			4'd0, 4'd4, 4'd8: begin
				far_led_d = 1'b0;
			end
			4'd1, 4'd5, 4'd9: begin
				file_kind  = irps_pkg::KIND_FAR;
				near_led_d = 1'b1;
			end
			4'd2, 4'd6: begin
				file_kind  = irps_pkg::KIND_OFF;
				near_led_d = 1'b0;
			end
			4'd3, 4'd7: begin
				file_kind = irps_pkg::KIND_NEAR;
				far_led_d = 1'b1;
			end
			4'd10: begin
				file_kind  = irps_pkg::KIND_OFF;
				near_led_d = 1'b0;
				therm_d    = 1'b1;
			end
			4'd11: begin
				file_kind = irps_pkg::KIND_NEAR;
			end
			4'd14: begin
				therm_d = 1'b0;
			end
			4'd15: begin
				far_led_d = 1'b1;
			end
			default: begin
			end
		endcase
		file_en = running && (file_kind != irps_pkg::KIND_NONE);
		case (file_kind)
			irps_pkg::KIND_FAR:  slot_sel = far_slot_q;
			irps_pkg::KIND_OFF:  slot_sel = off_slot_q;
			irps_pkg::KIND_NEAR: slot_sel = near_slot_q;
			default:             slot_sel = '0;
		endcase
		slot_next = (slot_sel == irps_pkg::SLOT_W'(irps_pkg::WINDOW_DEPTH - 1)) ?
			'0 : slot_sel + 1'b1;
		rd_addr = {file_kind, slot_sel};
	end

	always_comb begin
		old_s1 = rd_vld_s1 ? rd_s1 : '0;
		case (kind_s1)
			irps_pkg::KIND_FAR:  total_sel = far_total_q;
			irps_pkg::KIND_OFF:  total_sel = off_total_q;
			irps_pkg::KIND_NEAR: total_sel = near_total_q;
			default:             total_sel = '0;
		endcase
		// The outgoing sample is part of the sum, so the difference cannot go negative.
		total_new = total_sel - irps_pkg::TOTAL_W'(old_s1) + irps_pkg::TOTAL_W'(sample_s1);
	end

	// Window memory: read on acceptance, written back from stage 1. Two ticks in
	// a row never file into the same window, so a read never meets a pending write.
	always_ff @(posedge clk) begin
		if (accept && file_en) begin
			rd_s1 <= mem[rd_addr];
		end
		if (adv && valid_s1 && file_s1) begin
			mem[addr_s1] <= sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			file_s1   <= file_en;
			kind_s1   <= file_kind;
			addr_s1   <= rd_addr;
			sample_s1 <= in_data.adc_sample;
			rd_vld_s1 <= file_en && entry_vld_q[rd_addr];
			ctrl_s1   <= '{differential: in_data.differential_mode, running: running};
			leds_s1   <= {far_led_d, near_led_d, therm_d};
		end
		if (adv) begin
			ctrl_s2 <= ctrl_s1;
			leds_s2 <= leds_s1;
			leds_s3 <= leds_s2;
			out_data_q <= '{far_led_on: leds_s3[2], near_led_on: leds_s3[1],
				thermistor_selected: leds_s3[0], proximity_level: level};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_th_q     <= irps_pkg::FAR_THRESHOLD_RST;
			simple_th_q  <= irps_pkg::SIMPLE_THRESHOLD_RST;
			sat_th_q     <= irps_pkg::SAT_THRESHOLD_RST;
			phase_q      <= '0;
			warm_q       <= '0;
			far_led_q    <= 1'b0;
			near_led_q   <= 1'b0;
			therm_q      <= 1'b0;
			far_slot_q   <= '0;
			off_slot_q   <= '0;
			near_slot_q  <= '0;
			entry_vld_q  <= '0;
			far_total_q  <= '0;
			off_total_q  <= '0;
			near_total_q <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					irps_pkg::REG_FAR_THRESHOLD:    far_th_q    <= cfg_data;
					irps_pkg::REG_SIMPLE_THRESHOLD: simple_th_q <= cfg_data;
					irps_pkg::REG_SAT_THRESHOLD:    sat_th_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				phase_q    <= phase_q + 1'b1;
				far_led_q  <= far_led_d;
				near_led_q <= near_led_d;
				therm_q    <= therm_d;
				if (!running) begin
					warm_q <= warm_q + 1'b1;
				end
				if (file_en) begin
					case (file_kind)
						irps_pkg::KIND_FAR:  far_slot_q  <= slot_next;
						irps_pkg::KIND_OFF:  off_slot_q  <= slot_next;
						irps_pkg::KIND_NEAR: near_slot_q <= slot_next;
						default: begin
						end
					endcase
				end
			end
			if (adv) begin
				valid_s1    <= in_valid;
				valid_s2    <= valid_s1;
				valid_s3    <= valid_s2;
				out_valid_q <= valid_s3;
				if (valid_s1 && file_s1) begin
					entry_vld_q[addr_s1] <= 1'b1;
					case (kind_s1)
						irps_pkg::KIND_FAR:  far_total_q  <= total_new;
						irps_pkg::KIND_OFF:  off_total_q  <= total_new;
						irps_pkg::KIND_NEAR: near_total_q <= total_new;
						default: begin
						end
					endcase
				end
			end
		end
	end

	irps_classify u_classify (
		.clk                   (clk),
		.adv                   (adv),
		.ctrl                  (ctrl_s2),
		.far_total             (far_total_q),
		.off_total             (off_total_q),
		.near_total            (near_total_q),
		.far_threshold         (far_th_q),
		.simple_near_threshold (simple_th_q),
		.saturation_threshold  (sat_th_q),
		.level                 (level)
	);

endmodule

@@ tb/sv/tb_ir_proximity_sequencer.sv @@
// Self-checking testbench for the IR proximity sequencer: a directed table of ticks and
// register writes, then shaped random scenes, checked against a predictor of its own;
// some table rows give their own expected word. Depends on irps_pkg and ir_proximity_sequencer.
`timescale 1ns / 1ps

module tb_ir_proximity_sequencer;

	localparam int LATENCY      = 3;
	localparam int SETTLE       = LATENCY + 2;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 100;
	localparam int HOLD_AT      = 900;
	localparam int PHASES       = 8;
	localparam int PHASE_TICKS  = 200;
	localparam int PLAN_ROWS    = 29;
	localparam int SAMPLE_MAX   = (1 << irps_pkg::SAMPLE_W) - 1;
	localparam logic [irps_pkg::THRESH_W-1:0] THRESH_MAX = '1;
	// The block ignores writes to the one index left over.
	localparam logic [irps_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic {
		ROW_TICK,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                           kind;
		logic [irps_pkg::CFG_IDX_W-1:0]      reg_idx;
		logic [irps_pkg::THRESH_W-1:0]       value;
		logic                                diff;
		logic                                typed;
		irps_pkg::out_t                      want;
	} plan_row_t;

	localparam irps_pkg::out_t NO_RESULT = '0;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	irps_pkg::in_t                     in_data;
	logic                              out_valid;
	logic                              out_ready;
	irps_pkg::out_t                    out_data;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [irps_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [irps_pkg::THRESH_W-1:0]     cfg_data;

	// Predictor state.
	logic [3:0]                        ph_count;
	logic [irps_pkg::WARM_W-1:0]       warm_ticks;
	logic                              far_led;
	logic                              near_led;
	logic                              therm_sel;
	logic [irps_pkg::SAMPLE_W-1:0]     win_cell [3][irps_pkg::WINDOW_DEPTH];
	logic [irps_pkg::TOTAL_W-1:0]      win_sum [3];
	logic [irps_pkg::SLOT_W-1:0]       win_slot [3];
	logic [irps_pkg::THRESH_W-1:0]     far_thr;
	logic [irps_pkg::THRESH_W-1:0]     simple_thr;
	logic [irps_pkg::THRESH_W-1:0]     sat_thr;

	irps_pkg::out_t  pending [$];
	int    errors;
	int    results_seen;
	int    ticks_sent;
	int    diff_ticks;
	int    reg_writes;
	int    levels_seen [4];
	int    quiet_cycles;
	logic  calm;

	// Current random scene: ambient, far and near light levels.
	int    scene_left;
	int    amb_base;
	int    far_base;
	int    near_base;
	logic  scene_diff;

	plan_row_t plan [PLAN_ROWS] = '{
		// Warm-up ticks file nothing and report level off while the LEDs sequence.
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd0, 1'b0, 1'b1,
			'{1'b0, 1'b0, 1'b0, irps_pkg::LEVEL_OFF}},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b1, 1'b1,
			'{1'b0, 1'b1, 1'b0, irps_pkg::LEVEL_OFF}},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b0, 1'b1,
			'{1'b0, 1'b0, 1'b0, irps_pkg::LEVEL_OFF}},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd0, 1'b1, 1'b1,
			'{1'b1, 1'b0, 1'b0, irps_pkg::LEVEL_OFF}},
		// A zero saturation threshold saturates even empty windows.
		'{ROW_CFG, irps_pkg::REG_SAT_THRESHOLD, 13'd0, 1'b0, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd512, 1'b0, 1'b1,
			'{1'b0, 1'b0, 1'b0, irps_pkg::LEVEL_SATURATED}},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b1, 1'b1,
			'{1'b0, 1'b1, 1'b0, irps_pkg::LEVEL_SATURATED}},
		'{ROW_CFG, irps_pkg::REG_SAT_THRESHOLD, THRESH_MAX, 1'b0, 1'b0, NO_RESULT},
		'{ROW_CFG, irps_pkg::REG_FAR_THRESHOLD, 13'd0, 1'b0, 1'b0, NO_RESULT},
		'{ROW_CFG, irps_pkg::REG_SIMPLE_THRESHOLD, 13'd0, 1'b0, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd0, 1'b0, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b1, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b0, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b1, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd0, 1'b1, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b0, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd0, 1'b1, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b0, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd0, 1'b1, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b1, 1'b0, NO_RESULT},
		'{ROW_CFG, irps_pkg::REG_FAR_THRESHOLD, THRESH_MAX, 1'b0, 1'b0, NO_RESULT},
		'{ROW_CFG, irps_pkg::REG_SIMPLE_THRESHOLD, THRESH_MAX, 1'b0, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_SPARE, THRESH_MAX, 1'b0, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b1, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b0, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd0, 1'b1, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1023, 1'b0, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1, 1'b1, 1'b0, NO_RESULT},
		'{ROW_TICK, irps_pkg::REG_FAR_THRESHOLD, 13'd1022, 1'b0, 1'b0, NO_RESULT}
	};

	ir_proximity_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void file_sample(input irps_pkg::kind_t k,
			input logic [irps_pkg::SAMPLE_W-1:0] s);
		win_sum[k] = win_sum[k] - irps_pkg::TOTAL_W'(win_cell[k][win_slot[k]])
			+ irps_pkg::TOTAL_W'(s);
		win_cell[k][win_slot[k]] = s;
		win_slot[k] = (win_slot[k] == irps_pkg::WINDOW_DEPTH - 1) ? '0 : win_slot[k] + 1'b1;
	endfunction

	function automatic logic [irps_pkg::LEVEL_W-1:0] classify_level(input logic diff);
		logic [irps_pkg::TOTAL_W-1:0] nr;
		logic [irps_pkg::TOTAL_W-1:0] fr;
		logic [irps_pkg::TOTAL_W-1:0] amb;
		nr = win_sum[irps_pkg::KIND_NEAR];
		fr = win_sum[irps_pkg::KIND_FAR];
		amb = win_sum[irps_pkg::KIND_OFF];
		if (nr >= sat_thr || fr >= sat_thr)
			return irps_pkg::LEVEL_SATURATED;
		// Ambient correction, clamped at zero.
		nr = (nr > amb) ? nr - amb : '0;
		fr = (fr > amb) ? fr - amb : '0;
		if (!diff)
			return (nr >= simple_thr) ? irps_pkg::LEVEL_ON : irps_pkg::LEVEL_OFF;
		if (nr > fr && fr >= far_thr)
			return irps_pkg::LEVEL_ON;
		if (fr >= far_thr && 6 * nr >= 5 * fr)
			return irps_pkg::LEVEL_APPROACHING;
		return irps_pkg::LEVEL_OFF;
	endfunction

	function automatic irps_pkg::out_t predict_tick(input irps_pkg::in_t d);
		logic running;
		irps_pkg::out_t r;
		running = (warm_ticks >= irps_pkg::WARMUP_TICKS);
		case (ph_count)
			0, 4, 8: far_led = 1'b0;
			1, 5, 9: begin
				if (running)
					file_sample(irps_pkg::KIND_FAR, d.adc_sample);
				near_led = 1'b1;
			end
			2, 6: begin
				if (running)
					file_sample(irps_pkg::KIND_OFF, d.adc_sample);
				near_led = 1'b0;
			end
			3, 7: begin
				if (running)
					file_sample(irps_pkg::KIND_NEAR, d.adc_sample);
				far_led = 1'b1;
			end
			10: begin
				if (running)
					file_sample(irps_pkg::KIND_OFF, d.adc_sample);
				near_led = 1'b0;
				therm_sel = 1'b1;
			end
			11: begin
				if (running)
					file_sample(irps_pkg::KIND_NEAR, d.adc_sample);
			end
			14: therm_sel = 1'b0;
			15: far_led = 1'b1;
			default: ;
		endcase
		ph_count = ph_count + 1'b1;
		r.far_led_on = far_led;
		r.near_led_on = near_led;
		r.thermistor_selected = therm_sel;
		if (!running) begin
			warm_ticks = warm_ticks + 1'b1;
			r.proximity_level = irps_pkg::LEVEL_OFF;
		end else begin
			r.proximity_level = classify_level(d.differential_mode);
		end
		return r;
	endfunction

	// Samples follow the current scene on the phases that file them, with a little
	// jitter; now and then a word of pure noise breaks the pattern.
	function automatic irps_pkg::in_t shaped_tick();
		irps_pkg::in_t d;
		int base;
		if (scene_left == 0) begin
			scene_left = $urandom_range(90, 20);
			amb_base = $urandom_range(160);
			if ($urandom_range(5) == 0) begin
				far_base = $urandom_range(SAMPLE_MAX, 850);
				near_base = $urandom_range(SAMPLE_MAX, 850);
			end else begin
				far_base = amb_base + $urandom_range(320);
				near_base = amb_base + (far_base - amb_base) * $urandom_range(170, 50) / 100;
			end
			scene_diff = ($urandom_range(3) != 0);
		end
		scene_left--;
		case (ph_count)
			1, 5, 9: base = far_base;
			2, 6, 10: base = amb_base;
			3, 7, 11: base = near_base;
			default: base = $urandom_range(SAMPLE_MAX);
		endcase
		if ($urandom_range(9) == 0)
			base = $urandom_range(SAMPLE_MAX);
		base = base + int'($urandom_range(24)) - 12;
		if (base < 0)
			base = 0;
		else if (base > SAMPLE_MAX)
			base = SAMPLE_MAX;
		d.adc_sample = base[irps_pkg::SAMPLE_W-1:0];
		d.differential_mode = ($urandom_range(19) == 0) ? !scene_diff : scene_diff;
		return d;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with in_valid
	// still high, or at a later falling edge with in_valid low if the sender chose to idle.
	task automatic push_tick(input irps_pkg::in_t d, input logic typed,
			input irps_pkg::out_t want);
		irps_pkg::out_t guess;
		cfg_valid <= 1'b0;
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (!in_ready);
		guess = predict_tick(d);
		pending.push_back(typed ? want : guess);
		ticks_sent++;
		if (d.differential_mode)
			diff_ticks++;
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(99) < 23) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
	endtask

	task automatic write_reg(input logic [irps_pkg::CFG_IDX_W-1:0] idx,
			input logic [irps_pkg::THRESH_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			irps_pkg::REG_FAR_THRESHOLD: far_thr = val;
			irps_pkg::REG_SIMPLE_THRESHOLD: simple_thr = val;
			irps_pkg::REG_SAT_THRESHOLD: sat_thr = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	// Drains the block: every expected word back, then a settling wait.
	task automatic wait_idle();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic compare_field(input string field, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	initial begin : stimulus
		irps_pkg::in_t d;
		logic [irps_pkg::THRESH_W-1:0] far_v;
		logic [irps_pkg::THRESH_W-1:0] simple_v;
		logic [irps_pkg::THRESH_W-1:0] sat_v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		scene_left = 0;
		ph_count = '0;
		warm_ticks = '0;
		far_led = 1'b0;
		near_led = 1'b0;
		therm_sel = 1'b0;
		foreach (win_cell[k, s])
			win_cell[k][s] = '0;
		foreach (win_sum[k]) begin
			win_sum[k] = '0;
			win_slot[k] = '0;
		end
		far_thr = irps_pkg::FAR_THRESHOLD_RST;
		simple_thr = irps_pkg::SIMPLE_THRESHOLD_RST;
		sat_thr = irps_pkg::SAT_THRESHOLD_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(plan[i].reg_idx, plan[i].value);
			end else begin
				d.adc_sample = plan[i].value[irps_pkg::SAMPLE_W-1:0];
				d.differential_mode = plan[i].diff;
				push_tick(d, plan[i].typed, plan[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p % 5)
				0: begin
					far_v = irps_pkg::FAR_THRESHOLD_RST;
					simple_v = irps_pkg::SIMPLE_THRESHOLD_RST;
					sat_v = irps_pkg::SAT_THRESHOLD_RST;
				end
				1: begin
					far_v = '0;
					simple_v = '0;
					sat_v = '0;
				end
				2: begin
					far_v = THRESH_MAX;
					simple_v = THRESH_MAX;
					sat_v = THRESH_MAX;
				end
				3: begin
					far_v = irps_pkg::THRESH_W'($urandom_range(THRESH_MAX));
					simple_v = irps_pkg::THRESH_W'($urandom_range(THRESH_MAX));
					sat_v = irps_pkg::THRESH_W'($urandom_range(THRESH_MAX));
				end
				default: begin
					far_v = irps_pkg::THRESH_W'($urandom_range(600));
					simple_v = irps_pkg::THRESH_W'($urandom_range(1500));
					sat_v = irps_pkg::THRESH_W'($urandom_range(THRESH_MAX, 1500));
				end
			endcase
			wait_idle();
			write_reg(irps_pkg::REG_FAR_THRESHOLD, far_v);
			write_reg(irps_pkg::REG_SIMPLE_THRESHOLD, simple_v);
			write_reg(irps_pkg::REG_SAT_THRESHOLD, sat_v);
			if (p % 2 == 1)
				write_reg(REG_SPARE, irps_pkg::THRESH_W'($urandom_range(THRESH_MAX)));
			calm = (p == 3);
			for (int n = 0; n < PHASE_TICKS; n++) begin
				// Once, the sender stops mid-phase until the block has drained.
				if (p == 5 && n == PHASE_TICKS / 2)
					wait_idle();
				push_tick(shaped_tick(), 1'b0, NO_RESULT);
			end
		end
		calm = 1'b0;
		wait_idle();

		$display("Sent %0d ticks (%0d in differential mode) and %0d register writes.",
			ticks_sent, diff_ticks, reg_writes);
		$display("Checked %0d words; levels off %0d, approaching %0d, on %0d, saturated %0d.",
			results_seen, levels_seen[0], levels_seen[1], levels_seen[2], levels_seen[3]);
		if (errors == 0 && pending.size() == 0) begin
			$display("[ir_proximity_sequencer] OK");
		end else begin
			$display("[ir_proximity_sequencer] ERROR");
		end
		$finish;
	end

	initial begin : result_sink
		logic held_once;
		held_once = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			// One long hold-off while the sender keeps going, so the block backs up.
			if (!held_once && results_seen >= HOLD_AT) begin
				held_once = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= 23);
		end
	end

	// Words are captured at the rising edge and compared at the falling edge, so the
	// comparison never races the push of an expectation made at the same edge.
	initial begin : result_check
		logic got;
		irps_pkg::out_t seen;
		irps_pkg::out_t want;
		errors = 0;
		results_seen = 0;
		foreach (levels_seen[i])
			levels_seen[i] = 0;
		forever begin
			@(posedge clk);
			got = arst_n && out_valid && out_ready;
			seen = out_data;
			@(negedge clk);
			if (got) begin
				results_seen++;
				levels_seen[seen.proximity_level]++;
				if (pending.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected word, expected none, actual %p", $time, seen);
				end else begin
					want = pending.pop_front();
					compare_field("far_led_on", int'(want.far_led_on), int'(seen.far_led_on));
					compare_field("near_led_on", int'(want.near_led_on),
						int'(seen.near_led_on));
					compare_field("thermistor_selected", int'(want.thermistor_selected),
						int'(seen.thermistor_selected));
					compare_field("proximity_level", int'(want.proximity_level),
						int'(seen.proximity_level));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles, %0d still expected",
				$time, QUIET_LIMIT, pending.size());
			$display("[ir_proximity_sequencer] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
